FILE: design/edid_mode_table_checker_defines.svh
// ---------------------------------------------------------------------------
// edid mode table checker assertion macros
// shared assertion wrappers, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef EDID_MODE_TABLE_CHECKER_DEFINES_SVH
`define EDID_MODE_TABLE_CHECKER_DEFINES_SVH
`ifndef SYNTH
`define EDMTC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
`define EDMTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define EDMTC_ASSERT_SAME(lbl, ante, cons, msg)
`define EDMTC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/edmtc_pkg.sv
// ---------------------------------------------------------------------------
// edmtc package
// shared types, constants and established timing tables
// ---------------------------------------------------------------------------
`default_nettype none
package edmtc_pkg;
	localparam int BLOCK_BYTES = 128;
	localparam int ADDR_W = 7;
	localparam logic [6:0] EST_ADDR0 = 7'd35;
	localparam logic [6:0] EST_ADDR1 = 7'd36;
	localparam logic [6:0] STD_BASE = 7'd38;
	localparam logic [6:0] STD_LAST = 7'd53;
	localparam logic [6:0] DESC_BASE = 7'd54;
	localparam logic [6:0] DESC_LAST = 7'd125;
	localparam logic [4:0] DESC_LEN_M1 = 5'd17;
	localparam logic [4:0] DESC_CLK_OFF = 5'd9;
	localparam logic [7:0] RANGE_TAG = 8'hfd;
	localparam logic [11:0] CLK_NOT_GIVEN = 12'd2550;
	localparam logic [9:0] RATE_MAX = 10'd1023;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_CKSUM = 2'd1;
	localparam logic [1:0] ST_HDR = 2'd2;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
		logic [7:0] v;
		case (idx)
			3'd0: v = 8'h00;
			3'd7: v = 8'h00;
			default: v = 8'hff;
		endcase
		return v;
	endfunction

	function automatic logic [11:0] est_w(input logic [3:0] idx);
		logic [11:0] v;
		case (idx)
			4'd0, 4'd1: v = 12'd720;
			4'd2, 4'd3, 4'd4, 4'd5: v = 12'd640;
			4'd6, 4'd7, 4'd8, 4'd9: v = 12'd800;
			4'd10: v = 12'd832;
			4'd15: v = 12'd1280;
			default: v = 12'd1024;
		endcase
		return v;
	endfunction

	function automatic logic [11:0] est_h(input logic [3:0] idx);
		logic [11:0] v;
		case (idx)
			4'd0, 4'd1: v = 12'd400;
			4'd2, 4'd3, 4'd4, 4'd5: v = 12'd480;
			4'd6, 4'd7, 4'd8, 4'd9: v = 12'd600;
			4'd10: v = 12'd624;
			4'd15: v = 12'd1024;
			default: v = 12'd768;
		endcase
		return v;
	endfunction

	function automatic logic [9:0] est_r(input logic [3:0] idx);
		logic [9:0] v;
		case (idx)
			4'd0: v = 10'd70;
			4'd1: v = 10'd88;
			4'd2: v = 10'd60;
			4'd3: v = 10'd67;
			4'd4: v = 10'd72;
			4'd5: v = 10'd75;
			4'd6: v = 10'd56;
			4'd7: v = 10'd60;
			4'd8: v = 10'd72;
			4'd9: v = 10'd75;
			4'd10: v = 10'd75;
			4'd11: v = 10'd87;
			4'd12: v = 10'd60;
			4'd13: v = 10'd70;
			default: v = 10'd75;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

FILE: design/edmtc_byte_ram.sv
// ---------------------------------------------------------------------------
// edmtc byte ram
// 128 x 8 byte store, one write port, one registered read port
// ---------------------------------------------------------------------------
`default_nettype none
module edmtc_byte_ram (
	input wire logic clk,
	input wire logic we,
	input wire logic [edmtc_pkg::ADDR_W-1:0] waddr,
	input wire logic [7:0] wdata,
	input wire logic [edmtc_pkg::ADDR_W-1:0] raddr,
	output logic [7:0] rdata
);
	logic [7:0] mem [edmtc_pkg::BLOCK_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: design/edmtc_rate_div.sv
// ---------------------------------------------------------------------------
// edmtc rate divider
// pixel clock over total pixels, one quotient bit a cycle, saturating
// ---------------------------------------------------------------------------
`default_nettype none
module edmtc_rate_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [15:0] pclk_code,
	input wire logic [12:0] htot,
	input wire logic [12:0] vtot,
	output edmtc_pkg::div_stat_t stat,
	output logic [9:0] rate
);
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_SAT = 2'd1;
	localparam logic [1:0] PH_STEP = 2'd2;

	logic [1:0] phase_q;
	logic done_q;
	logic [29:0] p_q;
	logic [25:0] t_q;
	logic [3:0] k_q;
	logic [9:0] quo_q;
	logic [9:0] rate_q;
	logic [35:0] sh;
	logic ge;
	logic [9:0] quo_nx;

	always_comb begin
		sh = {10'b0, t_q} << k_q;
		ge = {6'b0, p_q} >= sh;
		quo_nx = quo_q | (ge ? (10'd1 << k_q) : 10'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_SAT;
					end
				end
				PH_SAT: begin
					if (t_q == 26'd0 || {7'b0, p_q} >= {1'b0, t_q, 10'b0}) begin
						phase_q <= PH_IDLE;
						done_q <= 1'b1;
					end else begin
						phase_q <= PH_STEP;
					end
				end
				PH_STEP: begin
					if (k_q == 4'd0) begin
						phase_q <= PH_IDLE;
						done_q <= 1'b1;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (start) begin
					p_q <= 30'(pclk_code * 30'd10000);
					t_q <= {13'b0, htot} * {13'b0, vtot};
				end
			end
			PH_SAT: begin
				k_q <= 4'd9;
				quo_q <= 10'd0;
				rate_q <= edmtc_pkg::RATE_MAX;
			end
			PH_STEP: begin
				if (ge) begin
					p_q <= p_q - sh[29:0];
				end
				quo_q <= quo_nx;
				k_q <= k_q - 4'd1;
				rate_q <= quo_nx;
			end
			default: ;
		endcase
	end

	assign stat.busy = (phase_q != PH_IDLE) || done_q;
	assign stat.done = done_q;
	assign rate = rate_q;
endmodule
`default_nettype wire

FILE: design/edmtc_query.sv
// ---------------------------------------------------------------------------
// edmtc query matcher
// compares a requested mode against all stored mode tables; no hit while the established mask is empty
// ---------------------------------------------------------------------------
`default_nettype none
module edmtc_query #(
	parameter int STANDARD_SLOTS = 8,
	parameter int DETAILED_SLOTS = 4
) (
	input wire logic [15:0] est_mask,
	input wire logic [STANDARD_SLOTS-1:0][30:0] std_modes,
	input wire logic [DETAILED_SLOTS-1:0][33:0] det_modes,
	input wire logic [11:0] qw,
	input wire logic [11:0] qh,
	input wire logic [9:0] qr,
	output logic hit
);
	logic [15:0] est_hit;
	logic [STANDARD_SLOTS-1:0] std_hit;
	logic [DETAILED_SLOTS-1:0] det_hit;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			est_hit[i] = est_mask[i] && edmtc_pkg::est_w(4'(i)) == qw
				&& edmtc_pkg::est_h(4'(i)) == qh && edmtc_pkg::est_r(4'(i)) == qr;
		end
		for (int i = 0; i < STANDARD_SLOTS; i++) begin
			std_hit[i] = std_modes[i][11:0] != 12'd0 && std_modes[i][11:0] == qw
				&& std_modes[i][23:12] == qh && {3'b0, std_modes[i][30:24]} == qr;
		end
		for (int i = 0; i < DETAILED_SLOTS; i++) begin
			det_hit[i] = det_modes[i][11:0] != 12'd0 && det_modes[i][11:0] == qw
				&& det_modes[i][23:12] == qh && det_modes[i][33:24] == qr;
		end
		hit = (est_mask != 16'd0) && ((|est_hit) || (|std_hit) || (|det_hit));
	end
endmodule
`default_nettype wire

FILE: design/edid_mode_table_checker.sv
// ---------------------------------------------------------------------------
// edid mode table checker
// loads an edid base block byte by byte, parses it into mode tables and
// answers mode queries
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready  | op, edid_byte, query_width/height/rate
//   out     | out_valid / out_ready| result_kind, status, supported, clock_limit_mhz
//
// a byte load writes the byte ram; a query result is registered in the output register
// the last byte starts a parse: on a failed check the status word goes out through
// the finish state, else after a sweep of bytes 35..125 of the byte ram and the
// rate divider tail of each detailed timing
// in_ready is low during a parse and while an unread result blocks the output
// reset clears position, tables and control; the byte ram is not cleared
// ---------------------------------------------------------------------------
`default_nettype none
`include "edid_mode_table_checker_defines.svh"
module edid_mode_table_checker #(
	parameter int STANDARD_SLOTS = 8,
	parameter int DETAILED_SLOTS = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic op,
	input wire logic [7:0] edid_byte,
	input wire logic [11:0] query_width,
	input wire logic [11:0] query_height,
	input wire logic [9:0] query_rate,
	output logic out_valid,
	input wire logic out_ready,
	output logic result_kind,
	output logic [1:0] status,
	output logic supported,
	output logic [11:0] clock_limit_mhz
);
	localparam int DN_W = $clog2(DETAILED_SLOTS + 1);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SWEEP = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0] state_q;
	logic [6:0] pos_q;
	logic [7:0] sum_q;
	logic hdr_ok_q;
	logic [1:0] pstat_q;
	logic [6:0] rd_addr_q;
	logic issue_q;
	logic vld_s1;
	logic [6:0] addr_s1;
	logic [7:0] rdata;
	logic [4:0] off_q;
	logic [7:0] dbyte_q [10];
	logic [7:0] b1_q;
	logic std_stop_q;
	logic [15:0] est_q;
	logic [STANDARD_SLOTS-1:0][30:0] std_q;
	logic [DETAILED_SLOTS-1:0][33:0] det_q;
	logic [DN_W-1:0] det_n_q;
	logic [11:0] clk_lim_q;
	logic [11:0] det_w_q;
	logic [11:0] det_h_q;
	logic out_valid_q;
	logic out_kind_q;
	logic [1:0] out_stat_q;
	logic out_sup_q;
	logic [11:0] out_clk_q;

	logic in_acc;
	logic ld_acc;
	logic q_acc;
	logic [7:0] sum_nx;
	logic [1:0] pstat_nx;
	logic sweep_done;
	logic in_std;
	logic in_desc;
	logic [2:0] sidx;
	logic [6:0] srel;
	logic [11:0] sw;
	logic [11:0] sh;
	logic [29:0] div5;
	logic [11:0] rl_clk;
	logic is_range;
	logic dv_start;
	logic [11:0] hact;
	logic [11:0] hbl;
	logic [11:0] vact;
	logic [11:0] vbl;
	edmtc_pkg::div_stat_t dv_stat;
	logic [9:0] dv_rate;
	logic q_hit;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign in_acc = in_valid && in_ready;
	assign ld_acc = in_acc && !op;
	assign q_acc = in_acc && op;

	always_comb begin
		sum_nx = ((pos_q == 7'd0) ? 8'd0 : sum_q) + edid_byte;
		if (sum_nx != 8'd0) begin
			pstat_nx = edmtc_pkg::ST_CKSUM;
		end else if (!hdr_ok_q) begin
			pstat_nx = edmtc_pkg::ST_HDR;
		end else begin
			pstat_nx = edmtc_pkg::ST_OK;
		end
	end

	edmtc_byte_ram u_ram (
		.clk(clk),
		.we(ld_acc),
		.waddr(pos_q),
		.wdata(edid_byte),
		.raddr(rd_addr_q),
		.rdata(rdata)
	);

	// decode of the byte in stage 1
	always_comb begin
		in_std = vld_s1 && addr_s1 >= edmtc_pkg::STD_BASE && addr_s1 <= edmtc_pkg::STD_LAST;
		in_desc = vld_s1 && addr_s1 >= edmtc_pkg::DESC_BASE;
		srel = addr_s1 - edmtc_pkg::STD_BASE;
		sidx = srel[3:1];
		sw = 12'({4'b0, b1_q} * 12'd8 + 12'd248);
		div5 = 30'({16'b0, sw, 2'b0} * 30'd52429);
		case (rdata[7:6])
			2'b01: sh = 12'((14'(sw) * 14'd3) >> 2);
			2'b10: sh = 12'(div5 >> 18);
			2'b11: sh = 12'((15'(sw) * 15'd9) >> 4);
			default: sh = 12'((15'(sw) * 15'd10) >> 4);
		endcase
		rl_clk = 12'({4'b0, rdata} * 12'd10);
		is_range = dbyte_q[0] == 8'd0 && dbyte_q[1] == 8'd0 && dbyte_q[2] == 8'd0
			&& dbyte_q[3] == edmtc_pkg::RANGE_TAG;
		hact = {dbyte_q[4][7:4], dbyte_q[2]};
		hbl = {dbyte_q[4][3:0], dbyte_q[3]};
		vact = {dbyte_q[7][7:4], dbyte_q[5]};
		vbl = {dbyte_q[7][3:0], dbyte_q[6]};
		dv_start = in_desc && off_q == edmtc_pkg::DESC_CLK_OFF
			&& !(dbyte_q[0] == 8'd0 && dbyte_q[1] == 8'd0);
		sweep_done = !issue_q && !vld_s1 && !dv_stat.busy;
	end

	edmtc_rate_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(dv_start),
		.pclk_code({dbyte_q[1], dbyte_q[0]}),
		.htot(13'(hact) + 13'(hbl)),
		.vtot(13'(vact) + 13'(vbl)),
		.stat(dv_stat),
		.rate(dv_rate)
	);

	edmtc_query #(
		.STANDARD_SLOTS(STANDARD_SLOTS),
		.DETAILED_SLOTS(DETAILED_SLOTS)
	) u_query (
		.est_mask(est_q),
		.std_modes(std_q),
		.det_modes(det_q),
		.qw(query_width),
		.qh(query_height),
		.qr(query_rate),
		.hit(q_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q <= 7'd0;
			issue_q <= 1'b0;
			vld_s1 <= 1'b0;
			off_q <= 5'd0;
			std_stop_q <= 1'b0;
			est_q <= 16'd0;
			std_q <= '0;
			det_q <= '0;
			det_n_q <= '0;
			clk_lim_q <= 12'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			vld_s1 <= issue_q;
			if (ld_acc) begin
				pos_q <= pos_q + 7'd1;
				if (pos_q == 7'(edmtc_pkg::BLOCK_BYTES - 1)) begin
					est_q <= 16'd0;
					std_q <= '0;
					det_q <= '0;
					det_n_q <= '0;
					clk_lim_q <= 12'd0;
					off_q <= 5'd0;
					std_stop_q <= 1'b0;
					if (pstat_nx == edmtc_pkg::ST_OK) begin
						state_q <= S_SWEEP;
						issue_q <= 1'b1;
					end else begin
						state_q <= S_FINISH;
					end
				end
			end
			if (q_acc) begin
				out_valid_q <= 1'b1;
			end
			case (state_q)
				S_SWEEP: begin
					if (issue_q && rd_addr_q == edmtc_pkg::DESC_LAST) begin
						issue_q <= 1'b0;
					end
					if (sweep_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: ;
			endcase
			if (vld_s1 && addr_s1 == edmtc_pkg::EST_ADDR0) begin
				for (int i = 0; i < 8; i++) begin
					est_q[i] <= rdata[7-i];
				end
			end
			if (vld_s1 && addr_s1 == edmtc_pkg::EST_ADDR1) begin
				for (int i = 0; i < 8; i++) begin
					est_q[8+i] <= rdata[7-i];
				end
			end
			if (in_std && addr_s1[0] && !std_stop_q) begin
				if (b1_q == 8'h01 && rdata == 8'h01) begin
					std_stop_q <= 1'b1;
				end else begin
					for (int s = 0; s < STANDARD_SLOTS; s++) begin
						if (sidx == 3'(s)) begin
							std_q[s] <= {7'(rdata[5:0]) + 7'd60, sh, sw};
						end
					end
				end
			end
			if (in_desc) begin
				off_q <= (off_q == edmtc_pkg::DESC_LEN_M1) ? 5'd0 : off_q + 5'd1;
				if (off_q == edmtc_pkg::DESC_CLK_OFF && is_range
					&& rl_clk != edmtc_pkg::CLK_NOT_GIVEN) begin
					clk_lim_q <= rl_clk;
				end
			end
			if (dv_stat.done && det_n_q < DN_W'(DETAILED_SLOTS)) begin
				for (int s = 0; s < DETAILED_SLOTS; s++) begin
					if (det_n_q == DN_W'(s)) begin
						det_q[s] <= {dv_rate, det_h_q, det_w_q};
					end
				end
				if (det_w_q != 12'd0) begin
					det_n_q <= det_n_q + DN_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_acc) begin
			sum_q <= sum_nx;
			if (pos_q < 7'd8) begin
				hdr_ok_q <= ((pos_q == 7'd0) ? 1'b1 : hdr_ok_q)
					&& (edid_byte == edmtc_pkg::hdr_byte(pos_q[2:0]));
			end
			if (pos_q == 7'(edmtc_pkg::BLOCK_BYTES - 1)) begin
				pstat_q <= pstat_nx;
				rd_addr_q <= edmtc_pkg::EST_ADDR0;
			end
		end
		if (issue_q) begin
			rd_addr_q <= rd_addr_q + 7'd1;
		end
		addr_s1 <= rd_addr_q;
		if (in_std && !addr_s1[0]) begin
			b1_q <= rdata;
		end
		if (in_desc && off_q < 5'd10) begin
			dbyte_q[off_q[3:0]] <= rdata;
		end
		if (dv_start) begin
			det_w_q <= hact;
			det_h_q <= vact;
		end
		if (q_acc) begin
			out_kind_q <= edmtc_pkg::KIND_QUERY;
			out_stat_q <= edmtc_pkg::ST_OK;
			out_sup_q <= q_hit;
			out_clk_q <= clk_lim_q;
		end else if (state_q == S_FINISH) begin
			out_kind_q <= edmtc_pkg::KIND_STATUS;
			out_stat_q <= pstat_q;
			out_sup_q <= 1'b0;
			out_clk_q <= clk_lim_q;
		end
	end

	assign out_valid = out_valid_q;
	assign result_kind = out_kind_q;
	assign status = out_stat_q;
	assign supported = out_sup_q;
	assign clock_limit_mhz = out_clk_q;

	`EDMTC_ASSERT_SAME(a_busy_no_ready, state_q != S_IDLE, !in_ready, "ready during parse")
	`EDMTC_ASSERT_SAME(a_sweep_no_out, state_q == S_SWEEP, !out_valid_q, "result during sweep")
	`EDMTC_ASSERT_SAME(a_div_free, dv_start, !dv_stat.busy, "divider restarted while busy")
	`EDMTC_ASSERT_NEXT(a_last_parses, ld_acc && pos_q == 7'd127, state_q != S_IDLE, "no parse")
endmodule
`default_nettype wire
